### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i outside reset.
`define PAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define PAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/pau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pau_pkg;

  localparam int DATA_W    = 24;
  localparam int FRAC_W    = 16;
  localparam int SLOPE_W   = FRAC_W + 1;
  localparam int DIV_STEPS = 17;
  localparam int VREM_W    = 24;
  localparam int SREM_W    = 31;

  localparam logic signed [DATA_W-1:0] FX_ONE      = 24'sd65536;
  localparam logic signed [DATA_W-1:0] FX_HALF     = 24'sd32768;
  localparam logic signed [DATA_W-1:0] FX_QUARTER  = 24'sd16384;
  localparam logic signed [DATA_W-1:0] FX_TWO      = 24'sd131072;
  localparam logic signed [DATA_W-1:0] FX_TWO_HALF = 24'sd163840;
  localparam logic signed [DATA_W-1:0] FX_SIX      = 24'sd393216;
  localparam logic signed [DATA_W-1:0] FX_C001     = 24'sd655;
  localparam logic signed [DATA_W-1:0] FX_C02      = 24'sd13107;
  localparam logic signed [DATA_W-1:0] FX_C256     = 24'sd256;

  typedef enum logic [3:0] {
    MODE_LINEAR   = 4'd0,
    MODE_RELU     = 4'd1,
    MODE_RELU6    = 4'd2,
    MODE_LEAKY    = 4'd3,
    MODE_LEAKY256 = 4'd4,
    MODE_TWICE6   = 4'd5,
    MODE_HSIG     = 4'd6,
    MODE_SQNL     = 4'd7,
    MODE_PARABLU  = 4'd8,
    MODE_SOFTSIGN = 4'd9,
    MODE_ELLIOT   = 4'd10
  } pau_mode_e;

  localparam logic [2:0] REG_MODE_ADDR = 3'd0;

  // One word in flight through the divider stages.
  typedef struct packed {
    logic                     valid;
    logic [3:0]               mode;
    logic                     neg;
    logic signed [DATA_W-1:0] y;
    logic [SLOPE_W-1:0]       d;
    logic [VREM_W-1:0]        vrem;
    logic [VREM_W-1:0]        vden;
    logic [DIV_STEPS-1:0]     vnum;
    logic [DIV_STEPS-1:0]     vq;
    logic [SREM_W-1:0]        srem;
    logic [SREM_W-1:0]        sden;
    logic [DIV_STEPS-1:0]     sq;
  } pau_stage_t;

endpackage
`default_nettype wire

### design/pau_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// One restoring step for both dividers, registered.
module pau_div_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire pau_pkg::pau_stage_t stage_i,
  output pau_pkg::pau_stage_t     stage_o
);

  pau_pkg::pau_stage_t stage_d, stage_q;
  logic [pau_pkg::VREM_W:0] vt;
  logic [pau_pkg::SREM_W:0] st;
  logic vbit, sbit;

  always_comb begin
    stage_d = stage_i;
    vt = {stage_i.vrem, stage_i.vnum[pau_pkg::DIV_STEPS-1]};
    st = {stage_i.srem, 1'b0};
    vbit = (vt >= {1'b0, stage_i.vden});
    sbit = (st >= {1'b0, stage_i.sden});
    stage_d.vrem = vbit ? pau_pkg::VREM_W'(vt - {1'b0, stage_i.vden})
                        : pau_pkg::VREM_W'(vt);
    stage_d.srem = sbit ? pau_pkg::SREM_W'(st - {1'b0, stage_i.sden})
                        : pau_pkg::SREM_W'(st);
    stage_d.vnum = {stage_i.vnum[pau_pkg::DIV_STEPS-2:0], 1'b0};
    stage_d.vq   = {stage_i.vq[pau_pkg::DIV_STEPS-2:0], vbit};
    stage_d.sq   = {stage_i.sq[pau_pkg::DIV_STEPS-2:0], sbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

### design/piecewise_activation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Activation unit: takes one signed Q8.16 sample per word and returns the
// selected activation value (signed Q8.16) and its derivative (unsigned Q1.16).
// The activation_mode register at byte address 0 selects linear, relu, relu6,
// leaky relu (0.01), leaky relu (1/256), leaky twice relu6, hard sigmoid, SQNL,
// Parablu, softsign or Elliot; codes 11 to 15 act as linear, and reset selects
// relu. Change the mode only while no word is in flight. The unit accepts one
// word every cycle while the output is not stalled, and each word passes
// through 21 registers on its way to the output: an input register,
// a stage of multipliers, a stage that forms the piecewise results and loads
// the dividers, 17 one-bit restoring divider stages used by softsign and
// Elliot, and the output register. The whole pipeline advances together, so a
// stalled output holds every word in place and nothing is lost.
`include "assert_macros.svh"
module piecewise_activation_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [23:0] x_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [23:0] act_value_o,
  output logic [16:0]      act_slope_o
);

  localparam int DW = pau_pkg::DATA_W;

  // Configuration register.
  logic [3:0] mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pau_pkg::MODE_RELU;
    end else if (psel && penable && pwrite && (paddr[2] == pau_pkg::REG_MODE_ADDR[2])) begin
      mode_q <= pwdata[3:0];
    end
  end
  assign pready = 1'b1;
  always_comb begin
    prdata = (paddr[2] == pau_pkg::REG_MODE_ADDR[2]) ? {28'd0, mode_q} : 32'd0;
  end

  // Global advance: the whole pipeline moves when the output is free.
  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: input register.
  logic v1_q;
  logic signed [DW-1:0] x1_q;
  logic [3:0] m1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= x_in_i;
      m1_q <= mode_q;
    end
  end

  // Stage 2: products, each rounded half up.
  logic signed [34:0] p001;
  logic signed [38:0] p02;
  logic signed [24:0] xm6;
  logic signed [39:0] p02m6;
  logic signed [47:0] pxx;
  logic [DW-1:0] ax, den;
  logic [47:0] pdd;
  logic signed [DW-1:0] c001_d, c02_d, c02m6_d;
  logic [30:0] xx_d, dd_d;

  always_comb begin
    p001  = 35'(x1_q) * 35'(pau_pkg::FX_C001);
    p02   = 39'(x1_q) * 39'(pau_pkg::FX_C02);
    xm6   = 25'(x1_q) - 25'(pau_pkg::FX_SIX);
    p02m6 = 40'(xm6) * 40'(pau_pkg::FX_C02);
    pxx   = 48'(x1_q) * 48'(x1_q);
    ax    = x1_q[DW-1] ? DW'(-x1_q) : DW'(x1_q);
    den   = ax + DW'(pau_pkg::FX_ONE);
    pdd   = 48'(den) * 48'(den);
    c001_d  = DW'((p001 + 35'sd32768) >>> 16);
    c02_d   = DW'((p02 + 39'sd32768) >>> 16);
    c02m6_d = DW'((p02m6 + 40'sd32768) >>> 16);
    xx_d    = 31'((pxx + 48'sd32768) >>> 16);
    dd_d    = 31'((pdd + 48'd32768) >> 16);
  end

  logic v2_q;
  logic signed [DW-1:0] x2_q, c001_q, c02_q, c02m6_q;
  logic [3:0] m2_q;
  logic [DW-1:0] ax2_q, den2_q;
  logic [30:0] xx2_q, dd2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q    <= x1_q;
      m2_q    <= m1_q;
      c001_q  <= c001_d;
      c02_q   <= c02_d;
      c02m6_q <= c02m6_d;
      ax2_q   <= ax;
      den2_q  <= den;
      xx2_q   <= xx_d;
      dd2_q   <= dd_d;
    end
  end

  // Stage 3: piecewise results and divider loading.
  pau_pkg::pau_stage_t s3_d;
  logic signed [DW-1:0] sq_t, halfx, c256, xx_s;
  localparam logic [pau_pkg::SLOPE_W-1:0] D_ONE = 17'd65536;
  localparam logic [pau_pkg::SLOPE_W-1:0] D_C02 = 17'd13107;

  always_comb begin
    sq_t  = DW'((xx2_q + 31'd2) >> 2);
    halfx = (x2_q + 24'sd1) >>> 1;
    c256  = (x2_q + 24'sd128) >>> 8;
    xx_s  = DW'(xx2_q);
    s3_d = '0;
    s3_d.valid = v2_q;
    s3_d.mode  = m2_q;
    s3_d.neg   = x2_q[DW-1];
    s3_d.y     = x2_q;
    s3_d.d     = D_ONE;
    case (m2_q)
      pau_pkg::MODE_RELU: begin
        s3_d.y = (x2_q > 0) ? x2_q : '0;
        s3_d.d = (x2_q > 0) ? D_ONE : '0;
      end
      pau_pkg::MODE_RELU6: begin
        if (x2_q >= pau_pkg::FX_SIX) begin
          s3_d.y = pau_pkg::FX_SIX;
          s3_d.d = '0;
        end else if (x2_q <= 0) begin
          s3_d.y = '0;
          s3_d.d = '0;
        end
      end
      pau_pkg::MODE_LEAKY: begin
        if (x2_q < 0) begin
          s3_d.y = c001_q;
          s3_d.d = 17'(pau_pkg::FX_C001);
        end
      end
      pau_pkg::MODE_LEAKY256: begin
        if (x2_q < 0) begin
          s3_d.y = c256;
          s3_d.d = 17'(pau_pkg::FX_C256);
        end
      end
      pau_pkg::MODE_TWICE6: begin
        if (x2_q < 0) begin
          s3_d.y = c02_q;
          s3_d.d = D_C02;
        end else if (x2_q >= pau_pkg::FX_SIX) begin
          s3_d.y = pau_pkg::FX_SIX + c02m6_q;
          s3_d.d = (x2_q > pau_pkg::FX_SIX) ? D_C02 : D_ONE;
        end
      end
      pau_pkg::MODE_HSIG: begin
        if (x2_q > pau_pkg::FX_TWO_HALF) begin
          s3_d.y = pau_pkg::FX_ONE;
          s3_d.d = '0;
        end else if (x2_q < -pau_pkg::FX_TWO_HALF) begin
          s3_d.y = '0;
          s3_d.d = '0;
        end else begin
          s3_d.y = c02_q + pau_pkg::FX_HALF;
          s3_d.d = D_C02;
        end
      end
      pau_pkg::MODE_SQNL: begin
        if (x2_q >= pau_pkg::FX_TWO) begin
          s3_d.y = pau_pkg::FX_ONE;
          s3_d.d = '0;
        end else if (x2_q <= -pau_pkg::FX_TWO) begin
          s3_d.y = -pau_pkg::FX_ONE;
          s3_d.d = '0;
        end else if (x2_q >= 0) begin
          s3_d.y = x2_q - sq_t;
          s3_d.d = 17'(pau_pkg::FX_ONE - halfx);
        end else begin
          s3_d.y = x2_q + sq_t;
          s3_d.d = 17'(pau_pkg::FX_ONE + halfx);
        end
      end
      pau_pkg::MODE_PARABLU: begin
        if (x2_q < 0) begin
          s3_d.y = '0;
          s3_d.d = '0;
        end else if (x2_q > pau_pkg::FX_HALF) begin
          s3_d.y = x2_q - pau_pkg::FX_QUARTER;
        end else begin
          s3_d.y = xx_s;
          s3_d.d = 17'(x2_q + x2_q);
        end
      end
      default: begin
      end
    endcase
    // Value divider: (|x| << 16) / den. Slope divider: 2^32 or 2^31 over dd.
    s3_d.vrem = ax2_q >> 1;
    s3_d.vden = den2_q;
    s3_d.vnum = {ax2_q[0], 16'd0};
    s3_d.srem = (m2_q == pau_pkg::MODE_ELLIOT) ? 31'd16384 : 31'd32768;
    s3_d.sden = dd2_q;
  end

  pau_pkg::pau_stage_t stg [0:pau_pkg::DIV_STEPS];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg[0] <= '0;
    end else if (en) begin
      stg[0] <= s3_d;
    end
  end

  for (genvar i = 0; i < pau_pkg::DIV_STEPS; i++) begin : g_div
    pau_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (stg[i]),
      .stage_o (stg[i+1])
    );
  end

  // Final selection and output register.
  pau_pkg::pau_stage_t sl;
  logic signed [DW-1:0] q_s, y_d;
  logic [pau_pkg::SLOPE_W-1:0] d_d;
  always_comb begin
    sl  = stg[pau_pkg::DIV_STEPS];
    q_s = sl.neg ? -DW'(sl.vq) : DW'(sl.vq);
    y_d = sl.y;
    d_d = sl.d;
    case (sl.mode)
      pau_pkg::MODE_SOFTSIGN: begin
        y_d = q_s;
        d_d = sl.sq;
      end
      pau_pkg::MODE_ELLIOT: begin
        y_d = ((q_s + 24'sd1) >>> 1) + pau_pkg::FX_HALF;
        d_d = sl.sq;
      end
      default: begin
      end
    endcase
  end

  logic [3:0] out_mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sl.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      act_value_o <= y_d;
      act_slope_o <= d_d;
      out_mode_q  <= sl.mode;
    end
  end
  assign out_valid_o = out_valid_q;

  `PAU_ASSERT(a_slope_max, out_valid_o && act_slope_o[16] |-> act_slope_o[15:0] == 16'd0, "slope above 1.0")
  `PAU_ASSERT(a_relu_nonneg, out_valid_o && out_mode_q == pau_pkg::MODE_RELU |-> !act_value_o[23], "relu value negative")
  `PAU_ASSERT(a_stall_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(act_value_o), "stalled word changed")
  `PAU_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule
`default_nettype wire
